// ----- hdl/csp_pkg.sv -----
package csp_pkg;

  // Sizing
  localparam int MAX_HEX_DIGITS   = 4;
  localparam int LEGACY_MAX_CHARS = 12;
  localparam int LEG_CNT_W        = $clog2(LEGACY_MAX_CHARS + 1);
  localparam int LEG_NIB_W        = 4 * LEGACY_MAX_CHARS;

  // Parse phases
  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_PCT_LEAD   = 4'd1;
  localparam logic [3:0] PH_PCT_PLUS   = 4'd2;
  localparam logic [3:0] PH_PCT_MINUS  = 4'd3;
  localparam logic [3:0] PH_PCT_POS    = 4'd4;
  localparam logic [3:0] PH_PCT_NEG    = 4'd5;
  localparam logic [3:0] PH_LEG_HASH   = 4'd6;
  localparam logic [3:0] PH_LEG_HEX    = 4'd7;
  localparam logic [3:0] PH_LEG_HEX_A  = 4'd8;
  localparam logic [3:0] PH_RGB_PREFIX = 4'd9;
  localparam logic [3:0] PH_RGBA_COLON = 4'd10;
  localparam logic [3:0] PH_COMP3      = 4'd11;
  localparam logic [3:0] PH_COMP4      = 4'd12;
  localparam logic [3:0] PH_TAIL3      = 4'd13;
  localparam logic [3:0] PH_TAIL4      = 4'd14;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LG     = 8'h67;
  localparam logic [7:0] CH_LR     = 8'h72;

  // Length rules for the rgb forms
  localparam logic [4:0] CC_MIN_RGB  = 5'd9;
  localparam logic [4:0] CC_MIN_RGBA = 5'd12;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [6:0] PCT_SAT  = 7'd101;

  // Alpha for 0..100 percent, rounded: (65535 * p + 50) / 100
  function automatic logic [101*16-1:0] build_pct_alpha();
    logic [101*16-1:0] tbl;
    tbl = '0;
    for (int p = 0; p <= 100; p++) begin
      tbl[p*16 +: 16] = 16'((65535 * p + 50) / 100);
    end
    return tbl;
  endfunction

  localparam logic [101*16-1:0] PCT_ALPHA_TBL = build_pct_alpha();

  typedef struct packed {
    logic [3:0]            phase;
    logic [4:0]            char_cnt;
    logic [1:0]            comp_idx;
    logic [3:0][15:0]      comp_val;
    logic [3:0][2:0]       comp_dig;
    logic [6:0]            pct_acc;
    logic [LEG_CNT_W-1:0]  leg_cnt;
    logic                  err;
  } csp_state_t;

  typedef struct packed {
    logic        spec_valid;
    logic [23:0] rgb_color;
    logic        alpha_present;
    logic [15:0] alpha_value;
  } csp_result_t;

endpackage

// ----- hdl/csp_parser.sv -----
module csp_parser
  import csp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           ch,
  output csp_state_t           st,
  output logic [LEG_NIB_W-1:0] leg_nib
);

  csp_state_t           st_r;
  csp_state_t           st_nxt;
  logic [LEG_NIB_W-1:0] nib_r;
  logic [LEG_NIB_W-1:0] nib_nxt;

  logic       is_dig;
  logic       is_ws;
  logic [3:0] hex_val;
  logic [10:0] pct_t;
  logic [6:0] pct_new;

  always_comb begin
    is_dig = (ch >= CH_0) && (ch <= CH_9);
    is_ws  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    if (is_dig) begin
      hex_val = ch[3:0];
    end else if (((ch >= CH_LA) && (ch <= CH_LF)) || ((ch >= CH_UA) && (ch <= CH_UF))) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      hex_val = 4'd0;
    end
    pct_t   = 11'(st_r.pct_acc) * 11'd10 + {7'd0, ch[3:0]};
    pct_new = (pct_t > 11'(PCT_SAT)) ? PCT_SAT : pct_t[6:0];
  end

  always_comb begin
    st_nxt  = st_r;
    nib_nxt = nib_r;
    if (step) begin
      if (ch == CH_NUL) begin
        st_nxt = '0;
      end else begin
        if (!st_r.err) begin
          unique case (st_r.phase) inside
            PH_START: begin
              if (ch == CH_HASH) st_nxt.phase = PH_LEG_HEX;
              else if (ch == CH_LBRACK) st_nxt.phase = PH_PCT_LEAD;
              else if (ch == CH_LR) st_nxt.phase = PH_RGB_PREFIX;
              else st_nxt.err = 1'b1;
            end
            PH_PCT_LEAD: begin
              if (is_ws) begin
                st_nxt.phase = st_r.phase;
              end else if (ch == CH_PLUS) begin
                st_nxt.phase = PH_PCT_PLUS;
              end else if (ch == CH_MINUS) begin
                st_nxt.phase = PH_PCT_MINUS;
              end else if (is_dig) begin
                st_nxt.pct_acc = pct_new;
                st_nxt.phase   = PH_PCT_POS;
              end else if ((ch == CH_RBRACK) && (st_r.char_cnt == 5'd1)) begin
                st_nxt.pct_acc = 7'd0;
                st_nxt.phase   = PH_LEG_HASH;
              end else begin
                st_nxt.err = 1'b1;
              end
            end
            PH_PCT_PLUS, PH_PCT_MINUS: begin
              if (is_dig) begin
                st_nxt.pct_acc = pct_new;
                st_nxt.phase   = (st_r.phase == PH_PCT_PLUS) ? PH_PCT_POS : PH_PCT_NEG;
              end else begin
                st_nxt.err = 1'b1;
              end
            end
            PH_PCT_POS, PH_PCT_NEG: begin
              if (is_dig) begin
                st_nxt.pct_acc = pct_new;
              end else if (ch == CH_RBRACK) begin
                // a negative nonzero percent acts as full
                if ((st_r.phase == PH_PCT_NEG) && (st_r.pct_acc != 7'd0)) begin
                  st_nxt.pct_acc = PCT_FULL;
                end
                st_nxt.phase = PH_LEG_HASH;
              end else begin
                st_nxt.err = 1'b1;
              end
            end
            PH_LEG_HASH: begin
              if (ch == CH_HASH) st_nxt.phase = PH_LEG_HEX_A;
              else st_nxt.err = 1'b1;
            end
            PH_LEG_HEX, PH_LEG_HEX_A: begin
              if (st_r.leg_cnt < LEG_CNT_W'(LEGACY_MAX_CHARS)) begin
                nib_nxt        = {nib_r[LEG_NIB_W-5:0], hex_val};
                st_nxt.leg_cnt = st_r.leg_cnt + 1'b1;
              end else begin
                st_nxt.err = 1'b1;
              end
            end
            PH_RGB_PREFIX: begin
              if (st_r.char_cnt == 5'd1) begin
                if (ch != CH_LG) st_nxt.err = 1'b1;
              end else if (st_r.char_cnt == 5'd2) begin
                if (ch != CH_LB) st_nxt.err = 1'b1;
              end else if (ch == CH_COLON) begin
                st_nxt.phase = PH_COMP3;
              end else if (ch == CH_LA) begin
                st_nxt.phase = PH_RGBA_COLON;
              end else begin
                st_nxt.err = 1'b1;
              end
            end
            PH_RGBA_COLON: begin
              if (ch == CH_COLON) st_nxt.phase = PH_COMP4;
              else st_nxt.err = 1'b1;
            end
            PH_COMP3, PH_COMP4: begin
              if (ch == CH_SLASH) begin
                if (st_r.comp_idx < ((st_r.phase == PH_COMP4) ? 2'd3 : 2'd2)) begin
                  st_nxt.comp_idx = st_r.comp_idx + 1'b1;
                end else begin
                  st_nxt.phase = (st_r.phase == PH_COMP4) ? PH_TAIL4 : PH_TAIL3;
                end
              end else begin
                st_nxt.comp_val[st_r.comp_idx] = {st_r.comp_val[st_r.comp_idx][11:0], hex_val};
                if (st_r.comp_dig[st_r.comp_idx] != 3'd7) begin
                  st_nxt.comp_dig[st_r.comp_idx] = st_r.comp_dig[st_r.comp_idx] + 1'b1;
                end
              end
            end
            default: begin
              st_nxt.phase = st_r.phase;
            end
          endcase
        end
        if (st_r.char_cnt != 5'd31) begin
          st_nxt.char_cnt = st_r.char_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // nibble history needs no reset: only the nibbles of the current spec are read
  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
  end

  assign st      = st_r;
  assign leg_nib = nib_r;

endmodule

// ----- hdl/csp_finish.sv -----
module csp_finish
  import csp_pkg::*;
(
  input  csp_state_t           st,
  input  logic [LEG_NIB_W-1:0] leg_nib,
  output csp_result_t          res
);

  function automatic logic [7:0] scale8(logic [15:0] v, logic [2:0] d);
    logic [31:0] w;
    logic [7:0]  r;
    w = {16'd0, v};
    r = 8'd0;
    for (int k = 1; k <= MAX_HEX_DIGITS; k++) begin
      if (d == 3'(k)) begin
        if (4 * k >= 8) r = 8'(w >> (4 * k - 8));
        else r = 8'(w << (8 - 4 * k));
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] scale16(logic [15:0] v, logic [2:0] d);
    logic [31:0] w;
    logic [15:0] r;
    w = {16'd0, v};
    r = 16'd0;
    for (int k = 1; k <= MAX_HEX_DIGITS; k++) begin
      if (d == 3'(k)) r = 16'(w << (16 - 4 * k));
    end
    return r;
  endfunction

  logic        ok;
  logic        four;
  logic [23:0] color;
  logic        have_a;
  logic [15:0] alpha;
  logic [6:0]  pc;
  logic [7:0]  byte_v [3];

  always_comb begin
    ok     = 1'b0;
    color  = 24'd0;
    have_a = 1'b0;
    alpha  = 16'hffff;
    four   = (st.phase == PH_COMP4) || (st.phase == PH_TAIL4);
    pc     = (st.pct_acc > PCT_FULL) ? PCT_FULL : st.pct_acc;
    for (int i = 0; i < 3; i++) byte_v[i] = 8'd0;

    if (!st.err && ((st.phase == PH_LEG_HEX) || (st.phase == PH_LEG_HEX_A))) begin
      if (st.leg_cnt == '0) begin
        ok = 1'b1;
      end
      for (int n = 1; n <= MAX_HEX_DIGITS; n++) begin
        if ((3 * n <= LEGACY_MAX_CHARS) && (st.leg_cnt == LEG_CNT_W'(3 * n))) begin
          ok = 1'b1;
          for (int i = 0; i < 3; i++) begin
            // first digit of component i sits (3n-1-i*n) nibbles above the newest
            byte_v[i][7:4] = leg_nib[4 * (3 * n - 1 - i * n) +: 4];
            if (n > 1) byte_v[i][3:0] = leg_nib[4 * (3 * n - 2 - i * n) +: 4];
          end
        end
      end
      color = {byte_v[0], byte_v[1], byte_v[2]};
      if (ok && (st.phase == PH_LEG_HEX_A)) begin
        have_a = 1'b1;
        alpha  = PCT_ALPHA_TBL[{pc, 4'd0} +: 16];
      end
    end else if (!st.err && ((st.phase == PH_COMP3) || (st.phase == PH_TAIL3) || four)) begin
      ok = (st.char_cnt >= (four ? CC_MIN_RGBA : CC_MIN_RGB)) &&
           (st.comp_idx == (four ? 2'd3 : 2'd2));
      for (int i = 0; i < 3; i++) begin
        if (st.comp_dig[i] > 3'(MAX_HEX_DIGITS)) ok = 1'b0;
      end
      if (four && (st.comp_dig[3] > 3'(MAX_HEX_DIGITS))) ok = 1'b0;
      color = {scale8(st.comp_val[0], st.comp_dig[0]),
               scale8(st.comp_val[1], st.comp_dig[1]),
               scale8(st.comp_val[2], st.comp_dig[2])};
      if (four) begin
        have_a = 1'b1;
        alpha  = scale16(st.comp_val[3], st.comp_dig[3]);
      end
    end

    if (!ok) begin
      color  = 24'd0;
      have_a = 1'b0;
      alpha  = 16'hffff;
    end
  end

  assign res.spec_valid    = ok;
  assign res.rgb_color     = color;
  assign res.alpha_present = have_a;
  assign res.alpha_value   = alpha;

endmodule

// ----- hdl/color_spec_string_parser_unit.sv -----
// Path: the parser takes a request from the input register; a terminating zero
//   loads the result register at that same edge, so out_valid rises once the zero has passed both registers.
// Throughput: one character per cycle; a zero only
//   waits while the result register still holds an untaken result.
// Reset: synchronous, active low; clears the input and result valid flags and the parse state
//   (the nibble history is left as is), so the next character starts a new spec.
module color_spec_string_parser_unit
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_spec_valid,
  output logic [23:0] out_rgb_color,
  output logic        out_alpha_present,
  output logic [15:0] out_alpha_value
);

  // Input register: holds one request until the parser takes it.
  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_char_r;

  // Result register: holds the result until the consumer takes it.
  logic        out_vld_r;
  logic        out_vld_nxt;
  csp_result_t out_res_r;

  logic        out_free;
  logic        step;
  logic        term;

  csp_state_t           st;
  logic [LEG_NIB_W-1:0] leg_nib;
  csp_result_t          res;

  // A non-zero character never produces a result, so it always advances. A zero needs
  // room in the result register, either empty or being drained this cycle.
  assign out_free = !out_vld_r || out_ready;
  assign step     = in_vld_r && ((in_char_r != CH_NUL) || out_free);
  assign term     = step && (in_char_r == CH_NUL);
  assign in_ready = !in_vld_r || step;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (term) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_byte;
    end
    if (term) begin
      out_res_r <= res;
    end
  end

  // Per-character state update; the terminator returns the state to start of string.
  csp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ch      (in_char_r),
    .st      (st),
    .leg_nib (leg_nib)
  );

  // End-of-string evaluation from the state built up before the terminator.
  csp_finish u_finish (
    .st      (st),
    .leg_nib (leg_nib),
    .res     (res)
  );

  assign out_valid         = out_vld_r;
  assign out_spec_valid    = out_res_r.spec_valid;
  assign out_rgb_color     = out_res_r.rgb_color;
  assign out_alpha_present = out_res_r.alpha_present;
  assign out_alpha_value   = out_res_r.alpha_value;

  // A terminator only advances when the result register can take its result.
  a_term_room: assert property (@(posedge clk) disable iff (!rst_n)
    term |-> (!out_vld_r || out_ready))
    else $error("terminator advanced over an untaken result");

  // A held request is neither dropped nor overwritten while it waits.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !step) |=> (in_vld_r && $stable(in_char_r)))
    else $error("waiting request lost or changed");

  // After a terminator the parser is back at start of string.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    term |=> ((st.phase == PH_START) && (st.char_cnt == 5'd0) && !st.err))
    else $error("parser not restarted after terminator");

  // A rejected spec carries the default color and alpha.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.spec_valid) |->
      ((out_res_r.rgb_color == 24'd0) && !out_res_r.alpha_present &&
       (out_res_r.alpha_value == 16'hffff)))
    else $error("rejected spec with non-default payload");

  // Without supplied alpha the alpha is full.
  a_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.alpha_present) |-> (out_res_r.alpha_value == 16'hffff))
    else $error("alpha not full when absent");

endmodule

// ----- tb/sv/color_spec_string_parser_unit_tb.sv -----
`timescale 1ns / 100ps

module color_spec_string_parser_unit_tb;
  import csp_pkg::*;

  // Marks a point in the request plan where the sender holds until every
  // expected result has come back.
  localparam int DRAIN_MARK = -1;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte      = CH_NUL;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic        out_spec_valid;
  logic [23:0] out_rgb_color;
  logic        out_alpha_present;
  logic [15:0] out_alpha_value;

  color_spec_string_parser_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_spec_valid    (out_spec_valid),
    .out_rgb_color     (out_rgb_color),
    .out_alpha_present (out_alpha_present),
    .out_alpha_value   (out_alpha_value)
  );

  always #4 clk = ~clk;

  // Request plan (characters, zero ends a spec) and the results predicted
  // for the terminators that the block has accepted so far.
  int          char_plan [$];
  int          spec_buf [$];
  csp_result_t color_results_q [$];
  int          stim_count  = 0;
  int          error_count = 0;
  int          results_seen = 0;

  // Parse state of the predictor, a shadow of what the block holds.
  logic [3:0]           ps_phase;
  logic [4:0]           ps_count;
  logic [1:0]           ps_index;
  logic [15:0]          ps_value [4];
  logic [2:0]           ps_digits [4];
  logic [6:0]           ps_percent;
  logic [3:0]           ps_nibble [LEGACY_MAX_CHARS];
  logic [LEG_CNT_W-1:0] ps_legacy_count;
  logic                 ps_error;

  // Sender and receiver pacing.
  int burst_left = 1;
  int gap_left   = 0;
  int hold_left  = 0;
  bit long_hold_done = 1'b0;
  int ready_mode = 0;
  int mode_left  = 0;
  int ready_tick = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 4'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
    // anything else counts as a zero digit
    return 4'd0;
  endfunction

  function automatic bit is_white(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_parse_state();
    ps_phase        = PH_START;
    ps_count        = '0;
    ps_index        = '0;
    ps_percent      = '0;
    ps_legacy_count = '0;
    ps_error        = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ps_value[i]  = '0;
      ps_digits[i] = '0;
    end
    for (int i = 0; i < LEGACY_MAX_CHARS; i++) ps_nibble[i] = '0;
  endfunction

  // Scale an n-digit component to a field of target bits: pure shifts.
  function automatic int scale_component(input int v, input int d, input int target);
    if (d == 0) return 0;
    if (4 * d >= target) return v >> (4 * d - target);
    return v << (target - 4 * d);
  endfunction

  // Work out the result that a terminating zero produces from the state.
  function automatic csp_result_t spec_outcome();
    csp_result_t r;
    bit ok;
    bit four;
    int n;
    int v;
    int pc;
    int color;
    int alpha;
    bit alpha_given;
    ok          = !ps_error;
    color       = 0;
    alpha       = 'hffff;
    alpha_given = 1'b0;
    if (ok && (ps_phase == PH_LEG_HEX || ps_phase == PH_LEG_HEX_A)) begin
      n = ps_legacy_count / 3;
      if (ps_legacy_count % 3 != 0 || n > MAX_HEX_DIGITS || ps_legacy_count > LEGACY_MAX_CHARS)
      begin
        ok = 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          v = 0;
          for (int j = 0; j < n; j++) v = (v << 4) | ps_nibble[i * n + j];
          v = v << (16 - 4 * n);
          color = (color << 8) | ((v >> 8) & 'hff);
        end
        if (ps_phase == PH_LEG_HEX_A) begin
          pc = (ps_percent > PCT_FULL) ? 100 : int'(ps_percent);
          alpha_given = 1'b1;
          alpha = (65535 * pc + 50) / 100;
        end
      end
    end else if (ok && (ps_phase == PH_COMP3 || ps_phase == PH_TAIL3 ||
                        ps_phase == PH_COMP4 || ps_phase == PH_TAIL4)) begin
      four = (ps_phase == PH_COMP4 || ps_phase == PH_TAIL4);
      n = four ? 4 : 3;
      if (ps_count < (four ? CC_MIN_RGBA : CC_MIN_RGB) || ps_index != n - 1) ok = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (ps_digits[i] > MAX_HEX_DIGITS) ok = 1'b0;
      end
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          color = (color << 8) | (scale_component(ps_value[i], ps_digits[i], 8) & 'hff);
        end
        if (four) begin
          alpha_given = 1'b1;
          alpha = scale_component(ps_value[3], ps_digits[3], 16) & 'hffff;
        end
      end
    end else begin
      ok = 1'b0;
    end
    if (!ok) begin
      color       = 0;
      alpha_given = 1'b0;
      alpha       = 'hffff;
    end
    r.spec_valid    = ok;
    r.rgb_color     = 24'(color);
    r.alpha_present = alpha_given;
    r.alpha_value   = 16'(alpha);
    return r;
  endfunction

  function automatic void add_percent_digit(input logic [7:0] c);
    int t;
    t = int'(ps_percent) * 10 + int'(c) - int'(CH_0);
    ps_percent = (t > PCT_SAT) ? PCT_SAT : 7'(t);
  endfunction

  // Advance the shadow parser by one accepted character.
  function automatic void predict_char(input logic [7:0] c);
    bit is_digit;
    logic [1:0] last;
    is_digit = (c >= CH_0 && c <= CH_9);
    if (c == CH_NUL) begin
      color_results_q.push_back(spec_outcome());
      clear_parse_state();
    end else begin
      if (!ps_error) begin
        case (ps_phase)
          PH_START: begin
            if (c == CH_HASH) ps_phase = PH_LEG_HEX;
            else if (c == CH_LBRACK) ps_phase = PH_PCT_LEAD;
            else if (c == CH_LR) ps_phase = PH_RGB_PREFIX;
            else ps_error = 1'b1;
          end
          PH_PCT_LEAD: begin
            if (!is_white(c)) begin
              if (c == CH_PLUS) ps_phase = PH_PCT_PLUS;
              else if (c == CH_MINUS) ps_phase = PH_PCT_MINUS;
              else if (is_digit) begin
                add_percent_digit(c);
                ps_phase = PH_PCT_POS;
              end else if (c == CH_RBRACK && ps_count == 5'd1) begin
                // "[]" stands for zero percent
                ps_percent = '0;
                ps_phase   = PH_LEG_HASH;
              end else ps_error = 1'b1;
            end
          end
          PH_PCT_PLUS, PH_PCT_MINUS: begin
            if (is_digit) begin
              add_percent_digit(c);
              ps_phase = (ps_phase == PH_PCT_PLUS) ? PH_PCT_POS : PH_PCT_NEG;
            end else ps_error = 1'b1;
          end
          PH_PCT_POS, PH_PCT_NEG: begin
            if (is_digit) add_percent_digit(c);
            else if (c == CH_RBRACK) begin
              // any negative value other than zero acts as full alpha
              if (ps_phase == PH_PCT_NEG && ps_percent != 0) ps_percent = PCT_FULL;
              ps_phase = PH_LEG_HASH;
            end else ps_error = 1'b1;
          end
          PH_LEG_HASH: begin
            if (c == CH_HASH) ps_phase = PH_LEG_HEX_A;
            else ps_error = 1'b1;
          end
          PH_LEG_HEX, PH_LEG_HEX_A: begin
            if (ps_legacy_count < LEGACY_MAX_CHARS) begin
              ps_nibble[ps_legacy_count] = hex_value(c);
              ps_legacy_count++;
            end else ps_error = 1'b1;
          end
          PH_RGB_PREFIX: begin
            if (ps_count == 5'd1) begin
              if (c != CH_LG) ps_error = 1'b1;
            end else if (ps_count == 5'd2) begin
              if (c != CH_LB) ps_error = 1'b1;
            end else if (c == CH_COLON) ps_phase = PH_COMP3;
            else if (c == CH_LA) ps_phase = PH_RGBA_COLON;
            else ps_error = 1'b1;
          end
          PH_RGBA_COLON: begin
            if (c == CH_COLON) ps_phase = PH_COMP4;
            else ps_error = 1'b1;
          end
          PH_COMP3, PH_COMP4: begin
            last = (ps_phase == PH_COMP4) ? 2'd3 : 2'd2;
            if (c == CH_SLASH) begin
              if (ps_index < last) ps_index++;
              else ps_phase = (ps_phase == PH_COMP4) ? PH_TAIL4 : PH_TAIL3;
            end else begin
              ps_value[ps_index] = {ps_value[ps_index][11:0], hex_value(c)};
              if (ps_digits[ps_index] < 3'd7) ps_digits[ps_index]++;
            end
          end
          default: ;  // tails ignore everything up to the zero
        endcase
      end
      if (ps_count < 5'd31) ps_count++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  // Append a finished spec and its terminator to the request plan.
  function automatic void commit_spec();
    foreach (spec_buf[i]) char_plan.push_back(spec_buf[i]);
    char_plan.push_back(CH_NUL);
    stim_count += spec_buf.size() + 1;
    spec_buf.delete();
  endfunction

  function automatic void push_spec(input string s);
    for (int i = 0; i < s.len(); i++) spec_buf.push_back(s[i]);
    commit_spec();
  endfunction

  function automatic int any_char();
    return $urandom_range(1, 255);
  endfunction

  // Mostly hex digits of either case, now and then a stray byte (never '/').
  function automatic int digit_char();
    int v;
    int c;
    if ($urandom_range(0, 7) != 0) begin
      v = $urandom_range(0, 21);
      if (v < 10) return CH_0 + v;
      if (v < 16) return CH_LA + v - 10;
      return CH_UA + v - 16;
    end
    c = any_char();
    while (c == CH_SLASH) c = any_char();
    return c;
  endfunction

  function automatic void build_legacy(input bit with_percent);
    int sign_pick;
    int len;
    if (with_percent) begin
      spec_buf.push_back(CH_LBRACK);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) spec_buf.push_back($urandom_range(0, 4) == 0 ?
                                                         CH_SPACE : $urandom_range(CH_TAB, CH_CR));
      end
      sign_pick = $urandom_range(0, 3);
      if (sign_pick == 1) spec_buf.push_back(CH_PLUS);
      if (sign_pick == 2) spec_buf.push_back(CH_MINUS);
      repeat ($urandom_range(0, 3)) spec_buf.push_back($urandom_range(CH_0, CH_9));
      spec_buf.push_back(CH_RBRACK);
    end
    spec_buf.push_back(CH_HASH);
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 14) : 3 * $urandom_range(0, 4);
    repeat (len) spec_buf.push_back(digit_char());
  endfunction

  function automatic void build_rgb(input bit four);
    int comps;
    spec_buf.push_back(CH_LR);
    spec_buf.push_back(CH_LG);
    spec_buf.push_back(CH_LB);
    if (four) spec_buf.push_back(CH_LA);
    spec_buf.push_back(CH_COLON);
    comps = four ? 4 : 3;
    for (int i = 0; i < comps; i++) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4))
        spec_buf.push_back(digit_char());
      if (i < comps - 1 && $urandom_range(0, 19) != 0) spec_buf.push_back(CH_SLASH);
    end
    // a trailing slash ends parsing; whatever follows is ignored
    if ($urandom_range(0, 3) == 0) begin
      spec_buf.push_back(CH_SLASH);
      repeat ($urandom_range(0, 4)) spec_buf.push_back(any_char());
    end
  endfunction

  function automatic void build_any_form();
    case ($urandom_range(0, 3))
      0: build_legacy(1'b0);
      1: build_legacy(1'b1);
      2: build_rgb(1'b0);
      default: build_rgb(1'b1);
    endcase
  endfunction

  // Damage a spec: overwrite or insert a character, or cut the tail from a random position.
  function automatic void break_spec();
    int pos;
    build_any_form();
    pos = $urandom_range(0, spec_buf.size() - 1);
    case ($urandom_range(0, 2))
      0: spec_buf[pos] = any_char();
      1: spec_buf.insert(pos, any_char());
      default: while (spec_buf.size() > pos) void'(spec_buf.pop_back());
    endcase
  endfunction

  function automatic void build_noise();
    if ($urandom_range(0, 1) == 0) spec_buf.push_back($urandom_range(0, 2) == 0 ? CH_LR :
                                                      ($urandom_range(0, 1) ? CH_HASH : CH_LBRACK));
    repeat ($urandom_range(0, 10)) spec_buf.push_back(any_char());
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer requests in bursts, predict each one as it is accepted
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_char(in_char_byte);
      // hold the current request until it is taken
      if (!in_valid || in_ready) begin
        if (char_plan.size() != 0 && char_plan[0] == DRAIN_MARK) begin
          // pause until the block has nothing left to deliver
          if (color_results_q.size() == 0) void'(char_plan.pop_front());
          in_valid <= 1'b0;
        end else if (char_plan.size() != 0 && gap_left == 0) begin
          in_valid     <= 1'b1;
          in_char_byte <= 8'(char_plan.pop_front());
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(10, 30);
              default:    gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall on a changing pattern, with one long hold-off
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    ready_tick++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 60) begin
      // back up the block far enough that its input stalls
      long_hold_done = 1'b1;
      hold_left      = 400;
      out_ready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_tick % 5 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each delivered result with the oldest prediction
  // ---------------------------------------------------------------------

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    csp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (color_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got valid=%0b color=0x%06h",
                 $time, out_spec_valid, out_rgb_color);
        error_count++;
      end else begin
        want = color_results_q.pop_front();
        check_field("spec_valid", want.spec_valid, out_spec_valid);
        check_field("rgb_color", want.rgb_color, out_rgb_color);
        check_field("alpha_present", want.alpha_present, out_alpha_present);
        check_field("alpha_value", want.alpha_value, out_alpha_value);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Plan the run, release reset, wait for the block to drain
  // ---------------------------------------------------------------------

  initial begin
    clear_parse_state();

    // empty spec, bad first character, lone hash and the legacy lengths
    push_spec("");
    push_spec("x#fff");
    push_spec("#");
    push_spec("#F0a");
    push_spec("#FFFFFFFFFFFF");
    push_spec("#123456789abc");
    push_spec("#12");
    push_spec("#1234567890abc");
    // stray bytes with the top bit set read as zero digits
    spec_buf.push_back(CH_HASH);
    spec_buf.push_back('hff);
    spec_buf.push_back('h80);
    spec_buf.push_back(CH_UF);
    commit_spec();
    // percent forms: empty, white space and sign, saturation, negative
    push_spec("[]#abc");
    push_spec("[ \t+100]#f0f");
    push_spec("[250]#123");
    push_spec("[-0]#123");
    push_spec("[-5]#123");
    push_spec("[+]#1");
    push_spec("[5 ]#1");
    push_spec("[ ]#1");
    push_spec("[50]x");
    // rgb forms: scaling, empty components, long components, short specs
    push_spec("rgb:f/0/8");
    push_spec("rgb:ffff/0000/1234");
    push_spec("rgb:12//34");
    push_spec("rgb:1//2");
    push_spec("rgb:12345/1/1");
    push_spec("rgb:1/2/3/tail");
    push_spec("rgbx:1/2/3");
    push_spec("rgba:ffff/8/80/800/tail");
    push_spec("rgba:1/2/3");
    char_plan.push_back(DRAIN_MARK);

    // random part: mostly well-formed specs with random content
    while (stim_count < 950) begin
      case ($urandom_range(0, 99)) inside
        [0:24]:  build_legacy(1'b0);
        [25:44]: build_legacy(1'b1);
        [45:64]: build_rgb(1'b0);
        [65:84]: build_rgb(1'b1);
        [85:92]: build_noise();
        default: break_spec();
      endcase
      commit_spec();
      if (stim_count >= 500 && stim_count < 520) char_plan.push_back(DRAIN_MARK);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (char_plan.size() != 0 || in_valid || color_results_q.size() != 0) @(posedge clk);
    // give a stray late result time to show up
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
